// File: sv/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // key width and width of the reported entry count
  localparam int DATA_W      = 32;
  localparam int COUNT_OUT_W = 11;

  // operation codes carried on the input word
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_APPEND  = 2'd2,
    OP_HEAPIFY = 2'd3
  } op_t;

  // status codes carried on the result word
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_LD,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_SEL,
    S_DN_CMP,
    S_HP_NEXT,
    S_HP_LD,
    S_FIN
  } state_t;

endpackage

// File: sv/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/mhpq_cmp.sv
// ----------------------------------------------------------------------------
// mhpq_cmp
// Shared signed key comparator used by every sift step.
// ----------------------------------------------------------------------------
module mhpq_cmp
  import mhpq_pkg::*;
(
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     lt
);

  // strict signed less-than
  assign lt = (a < b);

endmodule

// File: sv/min_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of signed 32-bit keys held in a single RAM, with insert,
// remove-minimum, unordered append and full heapify, one result word per op.
// ----------------------------------------------------------------------------
// One operation is accepted at a time and in_ready stays low until its result
// word has been loaded into the output register. The heap lives in one RAM
// with a registered read port, walked by a small sequencer that keeps the
// moving key in a register and uses one comparator. Append and rejected ops
// go straight to the result word. Insert reads the parent and compares at
// each level it climbs. Remove loads the last entry at the root, then per
// level reads the left and, if present, the right child, selects the smaller
// and compares it with the moving key. Heapify loads each of the count/2
// parents in turn, from the last toward the root, and sifts it down. The
// registered RAM read and the single read port set the pace of each step;
// a stalled result word holds the sequencer until the previous word leaves.
// The RAM needs no clearing after reset: only entries below the count are
// ever read.
// ----------------------------------------------------------------------------
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic signed [DATA_W-1:0] out_min_value,
  output logic [COUNT_OUT_W-1:0]   out_entry_count,
  output logic [1:0]               out_status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  state_t state_r, state_nxt;

  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [AW-1:0]            best_idx_r, best_idx_nxt;
  logic signed [DATA_W-1:0] cur_r, cur_nxt;
  logic signed [DATA_W-1:0] best_r, best_nxt;
  logic signed [DATA_W-1:0] root_r, root_nxt;
  logic signed [DATA_W-1:0] removed_r, removed_nxt;
  op_t                      op_r, op_nxt;
  status_t                  status_r, status_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_removed_r, out_removed_nxt;
  logic signed [DATA_W-1:0] out_min_r, out_min_nxt;
  logic [COUNT_OUT_W-1:0]   out_count_r, out_count_nxt;
  logic [1:0]               out_status_r, out_status_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic signed [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic signed [DATA_W-1:0] ram_rdata;

  logic signed [DATA_W-1:0] cmp_a, cmp_b;
  logic                     cmp_lt;

  // index arithmetic for the current position
  logic [XW-1:0] left_x, right_x, count_x;
  logic [AW-1:0] parent_idx;
  logic          is_full, is_empty, has_left, has_right, fin_go;

  assign left_x     = {1'b0, pos_r, 1'b1};
  assign right_x    = left_x + XW'(1);
  assign count_x    = XW'(count_r);
  assign has_left   = (left_x < count_x);
  assign has_right  = (right_x < count_x);
  assign parent_idx = (pos_r - AW'(1)) >> 1;
  assign is_full    = (count_r == CW'(CAPACITY));
  assign is_empty   = (count_r == '0);
  assign fin_go     = !out_valid_r || out_ready;

  // heap storage
  mhpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared comparator operand select
  always_comb begin
    cmp_a = cur_r;
    cmp_b = ram_rdata;
    unique case (state_r)
      S_DN_SEL: begin
        cmp_a = ram_rdata;
        cmp_b = best_r;
      end
      S_DN_CMP: begin
        cmp_a = best_r;
        cmp_b = cur_r;
      end
      default: begin
        cmp_a = cur_r;
        cmp_b = ram_rdata;
      end
    endcase
  end

  mhpq_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_op))
            OP_INSERT:  state_nxt = is_full ? S_FIN : S_UP_RD;
            OP_APPEND:  state_nxt = S_FIN;
            OP_REMOVE:  state_nxt = is_empty ? S_FIN : S_RM_LD;
            OP_HEAPIFY: state_nxt = S_HP_NEXT;
            default:    state_nxt = S_FIN;
          endcase
        end
      end
      S_UP_RD:   state_nxt = (pos_r == '0) ? S_FIN : S_UP_CMP;
      S_UP_CMP:  state_nxt = cmp_lt ? S_UP_RD : S_FIN;
      S_RM_LD:   state_nxt = S_DN_RDL;
      S_DN_RDL: begin
        if (has_left) begin
          state_nxt = S_DN_RDR;
        end else begin
          state_nxt = (op_r == OP_HEAPIFY) ? S_HP_NEXT : S_FIN;
        end
      end
      S_DN_RDR:  state_nxt = has_right ? S_DN_SEL : S_DN_CMP;
      S_DN_SEL:  state_nxt = S_DN_CMP;
      S_DN_CMP: begin
        if (cmp_lt) begin
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = (op_r == OP_HEAPIFY) ? S_HP_NEXT : S_FIN;
        end
      end
      S_HP_NEXT: state_nxt = (idx_r == '0) ? S_FIN : S_HP_LD;
      S_HP_LD:   state_nxt = S_DN_RDL;
      S_FIN:     state_nxt = fin_go ? S_IDLE : S_FIN;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    best_idx_nxt    = best_idx_r;
    cur_nxt         = cur_r;
    best_nxt        = best_r;
    removed_nxt     = removed_r;
    op_nxt          = op_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_removed_nxt = out_removed_r;
    out_min_nxt     = out_min_r;
    out_count_nxt   = out_count_r;
    out_status_nxt  = out_status_r;
    ram_we          = 1'b0;
    ram_waddr       = pos_r;
    ram_wdata       = cur_r;
    ram_raddr       = parent_idx;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = op_t'(in_op);
          removed_nxt = '0;
          status_nxt  = ST_OK;
          unique case (op_t'(in_op))
            OP_INSERT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                cur_nxt   = in_value;
                pos_nxt   = AW'(count_r);
                count_nxt = count_r + CW'(1);
              end
            end
            OP_APPEND: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_r);
                ram_wdata = in_value;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                removed_nxt = root_r;
                ram_raddr   = AW'(count_r - CW'(1));
                count_nxt   = count_r - CW'(1);
              end
            end
            OP_HEAPIFY: begin
              idx_nxt = count_r >> 1;
            end
            default: begin
              idx_nxt = idx_r;
            end
          endcase
        end
      end
      // sift up: climb while the moving key beats its parent
      S_UP_RD: begin
        if (pos_r == '0) begin
          ram_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = ram_rdata;
          pos_nxt   = parent_idx;
        end
      end
      // last entry arrives for the root
      S_RM_LD: begin
        cur_nxt = ram_rdata;
        pos_nxt = '0;
      end
      // sift down: fetch children, pick the smaller, move the hole
      S_DN_RDL: begin
        if (has_left) begin
          ram_raddr = left_x[AW-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      S_DN_RDR: begin
        best_nxt     = ram_rdata;
        best_idx_nxt = left_x[AW-1:0];
        ram_raddr    = right_x[AW-1:0];
      end
      S_DN_SEL: begin
        if (cmp_lt) begin
          best_nxt     = ram_rdata;
          best_idx_nxt = right_x[AW-1:0];
        end
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = best_r;
          pos_nxt   = best_idx_r;
        end
      end
      // heapify: next parent toward the root
      S_HP_NEXT: begin
        if (idx_r != '0) begin
          idx_nxt   = idx_r - CW'(1);
          ram_raddr = AW'(idx_r - CW'(1));
        end
      end
      S_HP_LD: begin
        cur_nxt = ram_rdata;
        pos_nxt = AW'(idx_r);
      end
      // load the result word
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt   = 1'b1;
          out_removed_nxt = removed_r;
          out_min_nxt     = is_empty ? '0 : root_r;
          out_count_nxt   = COUNT_OUT_W'(count_r);
          out_status_nxt  = status_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // shadow copy of the root entry
  assign root_nxt = (ram_we && ram_waddr == '0) ? ram_wdata : root_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    best_idx_r    <= best_idx_nxt;
    cur_r         <= cur_nxt;
    best_r        <= best_nxt;
    root_r        <= root_nxt;
    removed_r     <= removed_nxt;
    op_r          <= op_nxt;
    status_r      <= status_nxt;
    out_removed_r <= out_removed_nxt;
    out_min_r     <= out_min_nxt;
    out_count_r   <= out_count_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_min_value     = out_min_r;
  assign out_entry_count   = out_count_r;
  assign out_status        = out_status_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min-heap priority queue. A heap model inside
// the scoreboard predicts every result word. Stimulus runs a directed
// opening, a small-heap random mix, a fill to capacity with rejects on the
// full heap, and a drain with no idling. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_top
  import mhpq_pkg::*;
();

  localparam int CAPACITY     = 1024;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 60;

  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;

  // one predicted result word
  typedef struct {
    logic signed [DATA_W-1:0] removed;
    logic signed [DATA_W-1:0] min_key;
    logic [COUNT_OUT_W-1:0]   count;
    status_t                  status;
  } heap_report_t;

  // heap model plus the queue of predicted result words
  class heap_scoreboard;
    logic signed [DATA_W-1:0] keys [CAPACITY];
    int unsigned              held;
    heap_report_t             heap_reports [$];
    int unsigned              errors;
    int unsigned              ops_seen;
    int unsigned              words_checked;
    int unsigned              full_rejects;
    int unsigned              empty_removes;
    int unsigned              peak;

    function new();
      held          = 0;
      errors        = 0;
      ops_seen      = 0;
      words_checked = 0;
      full_rejects  = 0;
      empty_removes = 0;
      peak          = 0;
    endfunction

    function void swap_keys(int unsigned a, int unsigned b);
      logic signed [DATA_W-1:0] t;
      t       = keys[a];
      keys[a] = keys[b];
      keys[b] = t;
    endfunction

    // climb while strictly less than the parent
    function void sift_up(int unsigned pos);
      int unsigned parent;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (!(keys[pos] < keys[parent])) break;
        swap_keys(pos, parent);
        pos = parent;
      end
    endfunction

    // right child wins only when strictly smaller; swap only on strict greater
    function void sift_down(int unsigned pos, int unsigned cnt);
      int unsigned child;
      while (1) begin
        child = 2 * pos + 1;
        if (child >= cnt) break;
        if (child + 1 < cnt && keys[child + 1] < keys[child]) child++;
        if (!(keys[child] < keys[pos])) break;
        swap_keys(pos, child);
        pos = child;
      end
    endfunction

    // apply one accepted word to the model and queue its result
    function void note_word(op_t op, logic signed [DATA_W-1:0] value);
      heap_report_t r;
      int unsigned  i;
      r.removed = '0;
      r.status  = ST_OK;
      ops_seen++;
      case (op)
        OP_INSERT, OP_APPEND: begin
          if (held >= CAPACITY) begin
            r.status = ST_FULL;
            full_rejects++;
          end else begin
            keys[held] = value;
            held++;
            if (op == OP_INSERT) sift_up(held - 1);
          end
        end
        OP_REMOVE: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
            empty_removes++;
          end else begin
            r.removed = keys[0];
            keys[0]   = keys[held - 1];
            held--;
            sift_down(0, held);
          end
        end
        default: begin
          for (i = held / 2; i > 0; i--) sift_down(i - 1, held);
        end
      endcase
      r.min_key = (held > 0) ? keys[0] : '0;
      r.count   = COUNT_OUT_W'(held);
      if (held > peak) peak = held;
      heap_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [DATA_W-1:0] want,
                                logic signed [DATA_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    // compare one accepted result word with the oldest prediction
    function void check_word(logic signed [DATA_W-1:0] removed,
                             logic signed [DATA_W-1:0] min_key,
                             logic [COUNT_OUT_W-1:0] count, logic [1:0] status);
      heap_report_t e;
      if (heap_reports.size() == 0) begin
        errors++;
        $display("%0t: result word with no operation outstanding, expected none actual %0d",
                 $time, removed);
        return;
      end
      e = heap_reports.pop_front();
      words_checked++;
      compare_field("removed_value", e.removed, removed);
      compare_field("min_value", e.min_key, min_key);
      compare_field("entry_count", e.count, count);
      compare_field("status", e.status, status);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_op;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_removed_value;
  logic signed [DATA_W-1:0] out_min_value;
  logic [COUNT_OUT_W-1:0]   out_entry_count;
  logic [1:0]               out_status;

  logic        quiet;
  int unsigned stall_left;
  int unsigned cycles;

  heap_scoreboard sb;

  min_heap_priority_queue #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_removed_value(out_removed_value),
    .out_min_value    (out_min_value),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // random result side back-pressure: out_ready stays low while stall_left counts down
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result word monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_removed_value, out_min_value, out_entry_count, out_status);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, sb.heap_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // keys biased toward extremes and a narrow band for duplicates
  function automatic logic signed [DATA_W-1:0] rand_key();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return KEY_MAX;
          1:       return KEY_MIN;
          2:       return '0;
          default: return -1;
        endcase
      end
      1, 2:    return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  // weighted op choice, leftover percentage goes to heapify
  function automatic op_t pick_op(int unsigned ins, int unsigned rem, int unsigned app);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins) return OP_INSERT;
    if (r < ins + rem) return OP_REMOVE;
    if (r < ins + rem + app) return OP_APPEND;
    return OP_HEAPIFY;
  endfunction

  // present one word, optionally after an idle burst, and wait for acceptance
  task automatic send_word(op_t op, logic signed [DATA_W-1:0] value);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(op, value);
  endtask

  // stop sending until every predicted word has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.heap_reports.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned k;
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_INSERT;
    in_value   = '0;
    out_ready  = 1'b0;
    quiet      = 1'b0;
    stall_left = 0;
    cycles     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty heap, extremes, duplicates, unordered appends, heapify
    send_word(OP_REMOVE, 32'sd99);
    send_word(OP_HEAPIFY, KEY_MIN);
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_HEAPIFY, '0);
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, -1);
    send_word(OP_INSERT, -1);
    send_word(OP_APPEND, 32'sd5);
    send_word(OP_APPEND, -7);
    send_word(OP_APPEND, -1);
    send_word(OP_HEAPIFY, KEY_MAX);
    send_word(OP_INSERT, '0);
    // empty it out, the last remove hits the empty heap
    for (k = 0; k < 10; k++) send_word(OP_REMOVE, rand_key());
    hold_until_drained();

    // small-heap random mix with every op
    for (k = 0; k < 200; k++) begin
      send_word(pick_op(40, 35, 15), rand_key());
      if (k == 100) hold_until_drained();
    end

    // grow to capacity, then hit the full heap
    while (sb.held < CAPACITY) send_word(pick_op(50, 3, 47), rand_key());
    hold_until_drained();
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_APPEND, KEY_MAX);
    send_word(OP_INSERT, rand_key());
    send_word(OP_HEAPIFY, rand_key());

    // closing stretch with no idling on either side
    quiet <= 1'b1;
    for (k = 0; k < 120; k++) send_word(pick_op(30, 60, 10), rand_key());

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words sent, %0d results checked, peak depth %0d of %0d",
             sb.ops_seen, sb.words_checked, sb.peak, CAPACITY);
    $display("%0d removes on an empty heap, %0d rejects on a full heap, %0d mismatches",
             sb.empty_removes, sb.full_rejects, sb.errors);
    if (sb.errors == 0 && sb.heap_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/mhpq_pkg.sv
sv/mhpq_ram.sv
sv/mhpq_cmp.sv
sv/min_heap_priority_queue.sv
tb/tb_top.sv
